// File: design/ttod_pkg.sv
// ----------------------------------------------------------------------------
// ttod_pkg: shared types and constants of the Thompson tau outlier detector
// Holds the tau table in Q2.14, register codes and fixed field widths.
// ----------------------------------------------------------------------------
`default_nettype none

package ttod_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;
  localparam int OUT_IDX_W  = 6;
  localparam int TAU_W      = 16;
  localparam int TAU_N      = 107;
  localparam int TAU_IDX_W  = 7;
  localparam int LHS_SHIFT  = 28;
  localparam int GD2_W      = 2 * CFG_DATA_W;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_SORTED_MODE    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RECURSIVE_MODE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_USE_GIVEN      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_GIVEN_MEAN     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_GIVEN_DEV      = 3'd4;

  // Tau table entries used for large counts sit above the per-count entries.
  localparam logic [TAU_IDX_W-1:0] TAU_GT100  = 7'd101;
  localparam logic [TAU_IDX_W-1:0] TAU_GT150  = 7'd102;
  localparam logic [TAU_IDX_W-1:0] TAU_GT200  = 7'd103;
  localparam logic [TAU_IDX_W-1:0] TAU_GT500  = 7'd104;
  localparam logic [TAU_IDX_W-1:0] TAU_GT1000 = 7'd105;
  localparam logic [TAU_IDX_W-1:0] TAU_GT5000 = 7'd106;

  typedef int unsigned tau_raw_t [TAU_N];
  typedef logic [TAU_W-1:0] tau_arr_t [TAU_N];

  // Tau in units of 1e-4.
  localparam tau_raw_t TAU_RAW = '{
    0, 0, 0, 11511, 14250, 15712, 16563, 17110, 17491, 17770,
    17984, 18153, 18290, 18403, 18498, 18579, 18649, 18710, 18764, 18811,
    18853, 18891, 18926, 18957, 18985, 19011, 19035, 19057, 19078, 19096,
    19114, 19130, 19146, 19160, 19174, 19186, 19198, 19209, 19220, 19230,
    19240, 19248, 19257, 19265, 19273, 19280, 19288, 19294, 19301, 19307,
    19313, 19319, 19324, 19330, 19335, 19340, 19345, 19349, 19354, 19358,
    19362, 19366, 19370, 19373, 19377, 19381, 19384, 19387, 19390, 19393,
    19396, 19399, 19402, 19405, 19408, 19410, 19413, 19415, 19418, 19420,
    19422, 19424, 19427, 19429, 19431, 19433, 19435, 19437, 19439, 19440,
    19442, 19444, 19446, 19447, 19449, 19451, 19452, 19454, 19455, 19457,
    19458, 19506, 19530, 19572, 19586, 19597, 19600
  };

  function automatic tau_arr_t tau_build();
    tau_arr_t t;
    for (int i = 0; i < TAU_N; i++) begin
      t[i] = TAU_W'((TAU_RAW[i] * 16384 + 5000) / 10000);
    end
    return t;
  endfunction

  localparam tau_arr_t TAU_Q14 = tau_build();

endpackage

`default_nettype wire

// File: design/ttod_if.sv
// ----------------------------------------------------------------------------
// ttod_if: request channels of the Thompson tau outlier detector
// Input channel carries samples, output channel carries outlier results.
// ----------------------------------------------------------------------------
`default_nettype none

interface ttod_in_if #(parameter int SAMPLE_BITS = 16) ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample;
  logic                          set_end;
  modport source (output valid, sample, set_end, input ready);
  modport sink   (input valid, sample, set_end, output ready);
endinterface

interface ttod_out_if ();
  logic                           valid;
  logic                           ready;
  logic [ttod_pkg::OUT_IDX_W-1:0] outlier_index;
  logic                           found;
  logic                           run_end;
  modport source (output valid, outlier_index, found, run_end, input ready);
  modport sink   (input valid, outlier_index, found, run_end, output ready);
endinterface

`default_nettype wire

// File: design/ttod_store.sv
// ----------------------------------------------------------------------------
// ttod_store: sample memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module ttod_store #(
  parameter int DEPTH = 64,
  parameter int W     = 16,
  parameter int AW    = 6
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [W-1:0]  wdata,
  input  wire logic          re,
  input  wire logic [AW-1:0] raddr,
  output logic      [W-1:0]  rdata
);

  logic [W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// File: design/ttod_mul.sv
// ----------------------------------------------------------------------------
// ttod_mul: shared shift-add multiplier
// Unsigned product of two W-bit operands, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module ttod_mul #(
  parameter int W = 48
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           start,
  input  wire logic [W-1:0]   a,
  input  wire logic [W-1:0]   b,
  output logic                done,
  output logic [2*W-1:0]      prod
);

  localparam int CW = $clog2(W + 1);

  logic [W-1:0]   a_r;
  logic [2*W-1:0] p_r, p_nxt;
  logic [CW-1:0]  cnt_r;
  logic           busy_r, done_r;
  logic [W:0]     sum;

  // The upper half accumulates while the multiplier shifts out of the lower half.
  assign sum   = {1'b0, p_r[2*W-1:W]} + (p_r[0] ? {1'b0, a_r} : (W + 1)'(0));
  assign p_nxt = {sum, p_r[W-1:1]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CW'(W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r <= a;
      p_r <= {{W{1'b0}}, b};
    end else if (busy_r) begin
      p_r <= p_nxt;
    end
  end

  assign done = done_r;
  assign prod = p_r;

endmodule

`default_nettype wire

// File: design/thompson_tau_outlier_detect_core.sv
// ----------------------------------------------------------------------------
// thompson_tau_outlier_detect_core: modified Thompson tau outlier test
// Stores a set of samples, then runs the tau test with a small sequencer
// around one shared multiplier and reports the outlier indexes.
// ----------------------------------------------------------------------------
//
//  Channel | Direction | Payload                          | Handshake
//  --------+-----------+----------------------------------+-----------------
//  in_ch   | in        | sample, set_end                  | valid / ready
//  out_ch  | out       | outlier_index, found, run_end    | valid / ready
//  cfg_*   | in        | cfg_index, cfg_wdata             | cfg_we, no wait
//
// A sample request is taken whenever it is valid while the block loads a
// set. The request with set_end starts the test, and the block takes no
// request until every result of the run is in the output register. A pass
// sums the included samples and, with three or more, scans them for a
// candidate; with one it runs five products through the shared multiplier,
// MW bits wide (MW = 48 with the defaults). Emission walks the found flags
// one per cycle, but a stalled output holds its result in the output
// register and the sequencer waits until it is free. Reset is synchronous
// and clears the control state; the sample memory needs no clearing.
// ----------------------------------------------------------------------------
`default_nettype none

module thompson_tau_outlier_detect_core #(
  parameter int MAX_SAMPLES = 64,
  parameter int SAMPLE_BITS = 16
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  ttod_in_if.sink                               in_ch,
  ttod_out_if.source                            out_ch,
  input  wire logic                             cfg_we,
  input  wire logic [ttod_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [ttod_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  localparam int CNT_W  = $clog2(MAX_SAMPLES + 1);
  localparam int IDX_W  = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
  localparam int S_W    = SAMPLE_BITS + CNT_W;
  localparam int Q_W    = 2 * SAMPLE_BITS + CNT_W;
  localparam int NQ_W   = CNT_W + Q_W;
  localparam int VAR_W  = (NQ_W > ttod_pkg::GD2_W) ? NQ_W : ttod_pkg::GD2_W;
  localparam int DA_W   = SAMPLE_BITS + CNT_W + 2;
  localparam int DB_W   = (SAMPLE_BITS + 10 > 26) ? SAMPLE_BITS + 10 : 26;
  localparam int DIST_W = (DA_W > DB_W) ? DA_W : DB_W;
  localparam int MW0    = (VAR_W > DIST_W) ? VAR_W : DIST_W;
  localparam int MW     = (MW0 > 2 * ttod_pkg::TAU_W) ? MW0 : 2 * ttod_pkg::TAU_W;
  localparam int PW     = 2 * MW;
  localparam int CMP_W  = PW + ttod_pkg::LHS_SHIFT;
  localparam int T2_W   = 2 * ttod_pkg::TAU_W;

  typedef enum logic [6:0] {
    ST_LOAD  = 7'b0000001,
    ST_SUM   = 7'b0000010,
    ST_SCAN  = 7'b0000100,
    ST_MGO   = 7'b0001000,
    ST_MWAIT = 7'b0010000,
    ST_EMIT  = 7'b0100000,
    ST_CLEAR = 7'b1000000
  } state_t;

  // Which product the shared multiplier is working on.
  typedef enum logic [2:0] {
    MS_VAR  = 3'd0,
    MS_SQS  = 3'd1,
    MS_BEST = 3'd2,
    MS_TAU  = 3'd3,
    MS_RHS  = 3'd4
  } mstep_t;

  state_t st_r, st_nxt;
  mstep_t ms_r, ms_nxt;

  // Configuration.
  logic                                  sorted_r, recur_r, given_r;
  logic signed [ttod_pkg::CFG_DATA_W-1:0] gmean_r;
  logic [ttod_pkg::CFG_DATA_W-1:0]        gdev_r;

  // Set bookkeeping.
  logic [CNT_W-1:0]       cnt_r, cnt_nxt;
  logic [MAX_SAMPLES-1:0] excl_r, excl_nxt;
  logic [MAX_SAMPLES-1:0] fnd_r, fnd_nxt;
  logic [CNT_W-1:0]       fcnt_r, fcnt_nxt;
  logic [CNT_W-1:0]       ecnt_r, ecnt_nxt;
  logic [IDX_W-1:0]       ej_r, ej_nxt;

  // Scan pipeline.
  logic [CNT_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic             pv_r, pv_nxt;
  logic [IDX_W-1:0] pidx_r, pidx_nxt;
  logic             rd_en;
  logic [SAMPLE_BITS-1:0] mem_q;

  // Statistics of one pass.
  logic [CNT_W-1:0]        n_r, n_nxt;
  logic signed [S_W-1:0]   s_r, s_nxt;
  logic [Q_W-1:0]          q_r, q_nxt;
  logic [IDX_W-1:0]        first_r, first_nxt, last_r, last_nxt;
  logic [DIST_W-1:0]       best_r, best_nxt;
  logic [IDX_W-1:0]        pick_r, pick_nxt;
  logic                    pickv_r, pickv_nxt;
  logic [ttod_pkg::TAU_W-1:0] tau_r, tau_nxt;
  logic [VAR_W-1:0]        var_r, var_nxt;
  logic [2*DIST_W-1:0]     lhs_r, lhs_nxt;
  logic [T2_W-1:0]         t2_r, t2_nxt;

  // Output register.
  logic                           ov_r, ov_nxt;
  logic [ttod_pkg::OUT_IDX_W-1:0] oidx_r, oidx_nxt;
  logic                           ofnd_r, ofnd_nxt;
  logic                           oend_r, oend_nxt;

  // Sample datapath.
  logic signed [SAMPLE_BITS-1:0]       x;
  logic signed [2*SAMPLE_BITS-1:0]     sq;
  logic signed [CNT_W+SAMPLE_BITS:0]   nx;
  logic signed [DIST_W-1:0]            diff;
  logic [DIST_W-1:0]                   gap;
  logic [S_W-1:0]                      s_mag;
  logic                                incl, cand;
  logic [ttod_pkg::TAU_IDX_W-1:0]      tau_sel;

  // Multiplier.
  logic          mul_start, mul_done;
  logic [MW-1:0] mul_a, mul_b;
  logic [PW-1:0] mul_p;
  logic [CMP_W-1:0] lhs_cmp, rhs_cmp;

  logic in_acc, slot_free, scan_end;

  assign in_acc    = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (st_r == ST_LOAD);
  assign slot_free = !ov_r || out_ch.ready;

  ttod_store #(
    .DEPTH (MAX_SAMPLES),
    .W     (SAMPLE_BITS),
    .AW    (IDX_W)
  ) u_store (
    .clk   (clk),
    .we    (in_acc && (cnt_r < CNT_W'(MAX_SAMPLES))),
    .waddr (cnt_r[IDX_W-1:0]),
    .wdata (in_ch.sample),
    .re    (rd_en),
    .raddr (rd_ptr_r[IDX_W-1:0]),
    .rdata (mem_q)
  );

  ttod_mul #(.W(MW)) u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .prod  (mul_p)
  );

  // Distance of the sample leaving the memory from the mean, scaled so that
  // no division is needed: n*x - S, or 256*x - given mean.
  assign x    = $signed(mem_q);
  assign sq   = x * x;
  assign nx   = $signed({1'b0, n_r}) * x;
  assign diff = given_r ? (DIST_W'(x) <<< 8) - DIST_W'(gmean_r)
                        : DIST_W'(nx) - DIST_W'(s_r);
  assign gap   = diff[DIST_W-1] ? DIST_W'(-diff) : DIST_W'(diff);
  assign s_mag = s_r[S_W-1] ? S_W'(-s_r) : S_W'(s_r);
  assign incl  = pv_r && !excl_r[pidx_r];
  assign cand  = incl && (!sorted_r || pidx_r == first_r || pidx_r == last_r);
  assign rd_en = (st_r == ST_SUM || st_r == ST_SCAN) && (rd_ptr_r < cnt_r);
  assign scan_end = (rd_ptr_r == cnt_r) && !pv_r;

  always_comb begin
    if (32'(n_r) > 32'd5000) begin
      tau_sel = ttod_pkg::TAU_GT5000;
    end else if (32'(n_r) > 32'd1000) begin
      tau_sel = ttod_pkg::TAU_GT1000;
    end else if (32'(n_r) > 32'd500) begin
      tau_sel = ttod_pkg::TAU_GT500;
    end else if (32'(n_r) > 32'd200) begin
      tau_sel = ttod_pkg::TAU_GT200;
    end else if (32'(n_r) > 32'd150) begin
      tau_sel = ttod_pkg::TAU_GT150;
    end else if (32'(n_r) > 32'd100) begin
      tau_sel = ttod_pkg::TAU_GT100;
    end else begin
      tau_sel = ttod_pkg::TAU_IDX_W'(n_r);
    end
  end

  // Multiplier operands for each product.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (ms_r)
      MS_VAR: begin
        mul_a = given_r ? MW'(gdev_r) : MW'(n_r);
        mul_b = given_r ? MW'(gdev_r) : MW'(q_r);
      end
      MS_SQS: begin
        mul_a = MW'(s_mag);
        mul_b = MW'(s_mag);
      end
      MS_BEST: begin
        mul_a = MW'(best_r);
        mul_b = MW'(best_r);
      end
      MS_TAU: begin
        mul_a = MW'(tau_r);
        mul_b = MW'(tau_r);
      end
      MS_RHS: begin
        mul_a = MW'(t2_r);
        mul_b = MW'(var_r);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_start = (st_r == ST_MGO);
  assign lhs_cmp   = CMP_W'(lhs_r) << ttod_pkg::LHS_SHIFT;
  assign rhs_cmp   = CMP_W'(mul_p);

  always_comb begin
    st_nxt     = st_r;
    ms_nxt     = ms_r;
    cnt_nxt    = cnt_r;
    excl_nxt   = excl_r;
    fnd_nxt    = fnd_r;
    fcnt_nxt   = fcnt_r;
    ecnt_nxt   = ecnt_r;
    ej_nxt     = ej_r;
    rd_ptr_nxt = rd_ptr_r;
    pv_nxt     = rd_en;
    pidx_nxt   = rd_ptr_r[IDX_W-1:0];
    n_nxt      = n_r;
    s_nxt      = s_r;
    q_nxt      = q_r;
    first_nxt  = first_r;
    last_nxt   = last_r;
    best_nxt   = best_r;
    pick_nxt   = pick_r;
    pickv_nxt  = pickv_r;
    tau_nxt    = tau_r;
    var_nxt    = var_r;
    lhs_nxt    = lhs_r;
    t2_nxt     = t2_r;
    ov_nxt     = out_ch.ready ? 1'b0 : ov_r;
    oidx_nxt   = oidx_r;
    ofnd_nxt   = ofnd_r;
    oend_nxt   = oend_r;

    if (rd_en) begin
      rd_ptr_nxt = rd_ptr_r + 1'b1;
    end

    case (st_r)
      ST_LOAD: begin
        if (in_acc) begin
          if (cnt_r < CNT_W'(MAX_SAMPLES)) begin
            cnt_nxt = cnt_r + 1'b1;
          end
          if (in_ch.set_end) begin
            st_nxt     = ST_SUM;
            rd_ptr_nxt = '0;
            n_nxt      = '0;
            s_nxt      = '0;
            q_nxt      = '0;
          end
        end
      end
      ST_SUM: begin
        if (incl) begin
          n_nxt    = n_r + 1'b1;
          s_nxt    = s_r + S_W'(x);
          q_nxt    = q_r + Q_W'($unsigned(sq));
          last_nxt = pidx_r;
          if (n_r == '0) begin
            first_nxt = pidx_r;
          end
        end
        if (scan_end) begin
          if (n_r < CNT_W'(3)) begin
            st_nxt   = ST_EMIT;
            ej_nxt   = '0;
            ecnt_nxt = '0;
          end else begin
            st_nxt     = ST_SCAN;
            rd_ptr_nxt = '0;
            best_nxt   = '0;
            pickv_nxt  = 1'b0;
            tau_nxt    = ttod_pkg::TAU_Q14[tau_sel];
          end
        end
      end
      ST_SCAN: begin
        if (cand) begin
          if (sorted_r) begin
            if (pidx_r == first_r || !(best_r > gap)) begin
              best_nxt  = gap;
              pick_nxt  = pidx_r;
              pickv_nxt = 1'b1;
            end
          end else if (gap > best_r) begin
            best_nxt  = gap;
            pick_nxt  = pidx_r;
            pickv_nxt = 1'b1;
          end
        end
        if (scan_end) begin
          if (pickv_r) begin
            st_nxt = ST_MGO;
            ms_nxt = MS_VAR;
          end else begin
            st_nxt   = ST_EMIT;
            ej_nxt   = '0;
            ecnt_nxt = '0;
          end
        end
      end
      ST_MGO: begin
        st_nxt = ST_MWAIT;
      end
      ST_MWAIT: begin
        if (mul_done) begin
          st_nxt = ST_MGO;
          case (ms_r)
            MS_VAR: begin
              var_nxt = VAR_W'(mul_p);
              ms_nxt  = MS_SQS;
            end
            MS_SQS: begin
              if (!given_r) begin
                var_nxt = var_r - VAR_W'(mul_p);
              end
              ms_nxt = MS_BEST;
            end
            MS_BEST: begin
              lhs_nxt = (2 * DIST_W)'(mul_p);
              ms_nxt  = MS_TAU;
            end
            MS_TAU: begin
              t2_nxt = T2_W'(mul_p);
              ms_nxt = MS_RHS;
            end
            default: begin
              // Final compare of the squared distance against tau^2 * var.
              if (lhs_cmp > rhs_cmp) begin
                fnd_nxt[pick_r] = 1'b1;
                fcnt_nxt        = fcnt_r + 1'b1;
              end
              if (lhs_cmp > rhs_cmp && recur_r) begin
                excl_nxt[pick_r] = 1'b1;
                st_nxt     = ST_SUM;
                rd_ptr_nxt = '0;
                n_nxt      = '0;
                s_nxt      = '0;
                q_nxt      = '0;
              end else begin
                st_nxt   = ST_EMIT;
                ej_nxt   = '0;
                ecnt_nxt = '0;
              end
            end
          endcase
        end
      end
      ST_EMIT: begin
        if (fcnt_r == '0) begin
          if (slot_free) begin
            ov_nxt   = 1'b1;
            oidx_nxt = '0;
            ofnd_nxt = 1'b0;
            oend_nxt = 1'b1;
            st_nxt   = ST_CLEAR;
          end
        end else if (fnd_r[ej_r]) begin
          if (slot_free) begin
            ov_nxt   = 1'b1;
            oidx_nxt = ttod_pkg::OUT_IDX_W'(ej_r);
            ofnd_nxt = 1'b1;
            oend_nxt = (ecnt_r == fcnt_r - 1'b1);
            ecnt_nxt = ecnt_r + 1'b1;
            ej_nxt   = ej_r + 1'b1;
            if (ecnt_r == fcnt_r - 1'b1) begin
              st_nxt = ST_CLEAR;
            end
          end
        end else begin
          ej_nxt = ej_r + 1'b1;
        end
      end
      ST_CLEAR: begin
        cnt_nxt  = '0;
        excl_nxt = '0;
        fnd_nxt  = '0;
        fcnt_nxt = '0;
        st_nxt   = ST_LOAD;
      end
      default: begin
        st_nxt = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r     <= ST_LOAD;
      ms_r     <= MS_VAR;
      cnt_r    <= '0;
      excl_r   <= '0;
      fnd_r    <= '0;
      fcnt_r   <= '0;
      ecnt_r   <= '0;
      ej_r     <= '0;
      rd_ptr_r <= '0;
      pv_r     <= 1'b0;
      ov_r     <= 1'b0;
      sorted_r <= 1'b0;
      recur_r  <= 1'b0;
      given_r  <= 1'b0;
      gmean_r  <= '0;
      gdev_r   <= '0;
    end else begin
      st_r     <= st_nxt;
      ms_r     <= ms_nxt;
      cnt_r    <= cnt_nxt;
      excl_r   <= excl_nxt;
      fnd_r    <= fnd_nxt;
      fcnt_r   <= fcnt_nxt;
      ecnt_r   <= ecnt_nxt;
      ej_r     <= ej_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      pv_r     <= pv_nxt;
      ov_r     <= ov_nxt;
      if (cfg_we) begin
        case (cfg_index)
          ttod_pkg::CFG_SORTED_MODE:    sorted_r <= cfg_wdata[0];
          ttod_pkg::CFG_RECURSIVE_MODE: recur_r  <= cfg_wdata[0];
          ttod_pkg::CFG_USE_GIVEN:      given_r  <= cfg_wdata[0];
          ttod_pkg::CFG_GIVEN_MEAN:     gmean_r  <= $signed(cfg_wdata);
          ttod_pkg::CFG_GIVEN_DEV:      gdev_r   <= cfg_wdata;
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    pidx_r  <= pidx_nxt;
    n_r     <= n_nxt;
    s_r     <= s_nxt;
    q_r     <= q_nxt;
    first_r <= first_nxt;
    last_r  <= last_nxt;
    best_r  <= best_nxt;
    pick_r  <= pick_nxt;
    pickv_r <= pickv_nxt;
    tau_r   <= tau_nxt;
    var_r   <= var_nxt;
    lhs_r   <= lhs_nxt;
    t2_r    <= t2_nxt;
    oidx_r  <= oidx_nxt;
    ofnd_r  <= ofnd_nxt;
    oend_r  <= oend_nxt;
  end

  assign out_ch.valid         = ov_r;
  assign out_ch.outlier_index = oidx_r;
  assign out_ch.found         = ofnd_r;
  assign out_ch.run_end       = oend_r;

  // A sample is only ever excluded when it is flagged as an outlier.
  a_excl_le_found: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(excl_r) <= $countones(fnd_r))
    else $error("excluded sample without a reported outlier");

  // The flag counter tracks the found flags.
  a_fcnt_match: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(fnd_r) == 32'(fcnt_r))
    else $error("found counter out of step with found flags");

  // Each new set starts with no exclusions and no findings.
  a_load_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_LOAD) |-> (excl_r == '0 && fnd_r == '0))
    else $error("stale flags while loading");

  // A not-found result is always the whole run.
  a_notfound_end: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && !ofnd_r) |-> oend_r)
    else $error("not-found result without run end");

  // The multiplier only finishes while the sequencer waits for it.
  a_mul_wait: assert property (@(posedge clk) disable iff (!rst_n)
    mul_done |-> (st_r == ST_MWAIT))
    else $error("multiplier finished outside its wait state");

endmodule

`default_nettype wire
